### hdl/uaset_pkg.sv
// ----------------------------------------------------------------------------
// uaset_pkg
// shared types and codes for the unordered array set core and its cells
// ----------------------------------------------------------------------------
package uaset_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int ValueW           = 64;
    localparam int CountFieldW      = 5;

    // operation codes, opcode three is a no-op
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    // scan token handed from cell to cell
    typedef struct packed {
        logic tok;
        logic found;
    } link_t;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [ValueW-1:0] item_value;
    } req_item_t;

    typedef struct packed {
        logic [1:0]             status;
        logic                   is_member;
        logic [CountFieldW-1:0] entry_count;
    } rsp_item_t;

endpackage

### hdl/uaset_cell.sv
// ----------------------------------------------------------------------------
// uaset_cell
// one store entry; compares, inserts or shifts left as the scan token passes
// ----------------------------------------------------------------------------
module uaset_cell
    import uaset_pkg::*;
#(
    parameter int REM_W = 5
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        op,
    input  logic [ValueW-1:0] key,
    input  link_t             link_in,
    input  logic [REM_W-1:0]  rem_in,
    input  logic [ValueW-1:0] nbr_value,
    output link_t             link_out,
    output logic [REM_W-1:0]  rem_out,
    output logic [ValueW-1:0] value
);

    link_t             link_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ValueW-1:0] value_reg;
    logic [ValueW-1:0] value_next;
    logic              found_next;
    logic              active;
    logic              hit;

    always_comb
    begin
        // live entry: fewer than the live count cells passed so far
        active     = link_reg.tok && (rem_reg != '0);
        hit        = active && (value_reg == key);
        value_next = value_reg;
        found_next = link_reg.found;
        case (op)
            OP_INSERT:
            begin
                if (link_reg.tok && (rem_reg == '0) && !link_reg.found)
                begin
                    value_next = key;
                    found_next = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                // from the first match on, entries move one place down
                if (active && (link_reg.found || hit))
                begin
                    value_next = nbr_value;
                end
                found_next = link_reg.found || hit;
            end
            OP_QUERY:
            begin
                found_next = link_reg.found || hit;
            end
            default:
            begin
                found_next = link_reg.found;
            end
        endcase
    end

    assign link_out = '{tok: link_reg.tok, found: found_next};
    assign rem_out  = (rem_reg != '0) ? rem_reg - 1'b1 : rem_reg;
    assign value    = value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end
        else
        begin
            link_reg <= link_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_in;
        value_reg <= value_next;
    end

endmodule

### hdl/unsorted_array_set_core.sv
// the token walks the cell registers in turn; the row's found flag is registered, then the result
// one item at a time: the input stalls while the token walks the cell row
// the next item is taken at the edge that registers its predecessor's result
// reset: live count cleared, no token in flight, no result pending
// store contents are not cleared; only entries below the live count are ever read
// ----------------------------------------------------------------------------
// unsorted_array_set_core
// fixed-capacity unordered set of 64-bit values with insert, swap-free
// compacting remove and membership query, built as a row of cells
// ----------------------------------------------------------------------------
module unsorted_array_set_core
    import uaset_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    localparam int REM_W = $clog2(CAPACITY + 1);

    // controller state
    state_t            state_reg;
    state_t            state_next;
    logic [REM_W-1:0]  count_reg;
    logic [REM_W-1:0]  count_next;
    logic [1:0]        op_reg;
    logic [ValueW-1:0] key_reg;
    logic              found_reg;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    rsp_item_t         rsp_reg;
    rsp_item_t         rsp_next;

    // handshake decode
    logic              accept;
    logic              emit;
    logic              rsp_free;
    logic              exit_tok;

    // cell row wiring; index CAPACITY is the token leaving the last cell
    link_t             link_chain [CAPACITY+1];
    logic [REM_W-1:0]  rem_chain  [CAPACITY+1];
    logic [ValueW-1:0] cell_value [CAPACITY];

    logic [REM_W+CountFieldW-1:0] count_ext;

    assign rsp_free = !rsp_valid_reg || !rsp_stall;
    assign accept   = req_valid && !req_stall;
    assign exit_tok = link_chain[CAPACITY].tok;

    // ---------------------------------------------------------------------
    // next state
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // token has walked the whole row
                if (exit_tok)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (emit)
                begin
                    state_next = accept ? S_SCAN : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // state machine outputs
    // ---------------------------------------------------------------------
    always_comb
    begin
        emit      = 1'b0;
        req_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
            end
            S_SCAN:
            begin
                req_stall = 1'b1;
            end
            S_DONE:
            begin
                // result leaves and the next item may enter in the same cycle
                emit      = rsp_free;
                req_stall = !rsp_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // result and count update, from the found flag carried out of the row
    // ---------------------------------------------------------------------
    always_comb
    begin
        count_next       = count_reg;
        rsp_next.status  = ST_DONE;
        rsp_next.is_member = 1'b0;
        case (op_reg)
            OP_INSERT:
            begin
                if (found_reg)
                begin
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    rsp_next.status = ST_FULL;
                end
            end
            OP_REMOVE:
            begin
                if (found_reg)
                begin
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    rsp_next.status = ST_NOTFOUND;
                end
            end
            OP_QUERY:
            begin
                rsp_next.is_member = found_reg;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        count_ext            = {{CountFieldW{1'b0}}, count_next};
        rsp_next.entry_count = count_ext[CountFieldW-1:0];
    end

    assign rsp_valid_next = emit || (rsp_valid_reg && rsp_stall);

    // token enters the first cell with the live count as its budget
    assign link_chain[0] = '{tok: accept, found: 1'b0};
    assign rem_chain[0]  = emit ? count_next : count_reg;

    // ---------------------------------------------------------------------
    // row of cells
    // ---------------------------------------------------------------------
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [ValueW-1:0] nbr;

        if (i == CAPACITY - 1)
        begin : g_last
            assign nbr = '0;
        end
        else
        begin : g_mid
            assign nbr = cell_value[i+1];
        end

        uaset_cell #(
            .REM_W (REM_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .op        (op_reg),
            .key       (key_reg),
            .link_in   (link_chain[i]),
            .rem_in    (rem_chain[i]),
            .nbr_value (nbr),
            .link_out  (link_chain[i+1]),
            .rem_out   (rem_chain[i+1]),
            .value     (cell_value[i])
        );
    end

    // ---------------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            // live count moves only when the result of an item is taken
            if (emit)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= req.opcode;
            key_reg <= req.item_value;
        end
        if (exit_tok)
        begin
            found_reg <= link_chain[CAPACITY].found;
        end
        if (emit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= REM_W'(CAPACITY))
        else $error("live count above capacity");

    a_exit_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        exit_tok |-> (state_reg == S_SCAN))
        else $error("token left the row outside a scan");

    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_SCAN))
        else $error("accepted item did not start a scan");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !emit |=> (count_reg == $past(count_reg)))
        else $error("live count changed without a result");

    a_no_result_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (!emit && req_stall))
        else $error("result or item taken during a scan");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the unordered array set core against its own model of the store,
// using directed items, weighted random traffic, random idling and a long hold-off
// ----------------------------------------------------------------------------
module testbench;
    import uaset_pkg::*;

    localparam int CAPACITY      = DEFAULT_CAPACITY;
    // slowest pass is ~1900 items plus stalls, so this is ample
    localparam int CYCLE_LIMIT   = 1_000_000;
    // worst-case latency of one item plus some margin
    localparam int SETTLE_CYCLES = CAPACITY + 8;
    localparam int PHASE_ITEMS   = 600;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_ITEMS    = 30;
    localparam int POOL_SIZE     = 8;

    // opcode three does nothing, the package leaves it unnamed
    localparam logic [1:0]        OP_NOP   = 2'd3;
    localparam logic [ValueW-1:0] ALT_BITS = 64'h5555_5555_5555_5555;

    // clock, reset and the two channels
    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_item_t req       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_item_t rsp;

    // idling rates in percent, and the long receiver hold-off
    int   send_idle_pct  = 0;
    int   recv_idle_pct  = 0;
    int   hold_request   = 0;
    logic recv_hold      = 1'b0;
    int   mismatch_count = 0;
    int   cycle_count;

    // shadow of the set: live entries in model order and their number
    logic [ValueW-1:0] held_values [CAPACITY];
    int                held_count = 0;
    rsp_item_t         awaited_results [$];

    // values reused on purpose so that duplicates and hits are common
    logic [ValueW-1:0] value_pool [POOL_SIZE];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    unsorted_array_set_core #(
        .CAPACITY (CAPACITY)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // ------------------------------------------------------------------------
    // set model: applies one accepted item, returns the result it must give
    // ------------------------------------------------------------------------
    function automatic rsp_item_t apply_set_op(req_item_t item);
        rsp_item_t outcome;
        int        hit_slot;
        outcome          = '0;
        outcome.status   = ST_DONE;
        hit_slot         = held_count;
        // first live entry with the same bit pattern
        for (int i = held_count - 1; i >= 0; i--)
        begin
            if (held_values[i] == item.item_value)
                hit_slot = i;
        end
        case (item.opcode)
            OP_INSERT:
            begin
                if (held_count >= CAPACITY)
                    outcome.status = ST_FULL;
                else
                begin
                    held_values[held_count] = item.item_value;
                    held_count++;
                end
            end
            OP_REMOVE:
            begin
                // last live entry fills the hole, the order is irrelevant
                if (hit_slot >= held_count)
                    outcome.status = ST_NOTFOUND;
                else
                begin
                    held_values[hit_slot] = held_values[held_count - 1];
                    held_count--;
                end
            end
            OP_QUERY:
                outcome.is_member = (hit_slot < held_count);
            default:
                ;
        endcase
        outcome.entry_count = CountFieldW'(held_count);
        return outcome;
    endfunction

    // ------------------------------------------------------------------------
    // sender: optional idle gap, then offer the item until it is taken
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [1:0] op, input logic [ValueW-1:0] value);
        req_item_t item;
        item.opcode     = op;
        item.item_value = value;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        // taken at this edge, so the model moves on in the same order
        awaited_results.push_back(apply_set_op(item));
    endtask

    // sender goes quiet until every result is back, then lets the core settle
    task automatic wait_all_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // one random item with the given weights for insert and remove
    task automatic send_random_item(input int insert_pct, input int remove_pct);
        int                roll;
        logic [1:0]        op;
        logic [ValueW-1:0] value;
        roll = $urandom_range(99);
        if (roll < insert_pct)
            op = OP_INSERT;
        else if (roll < insert_pct + remove_pct)
            op = OP_REMOVE;
        else if (roll < 98)
            op = OP_QUERY;
        else
            op = OP_NOP;
        // lookups mostly aim at live entries, otherwise pool or fresh bits
        roll = $urandom_range(99);
        if (op != OP_INSERT && held_count > 0 && roll < 60)
            value = held_values[$urandom_range(held_count - 1)];
        else if (roll < 75)
            value = value_pool[$urandom_range(POOL_SIZE - 1)];
        else
            value = {$urandom, $urandom};
        send_item(op, value);
    endtask

    // ------------------------------------------------------------------------
    // result checker and receiver stall, sampled and driven on the same edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        rsp_item_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("unexpected result item: status %0d, is_member %0d, entry_count %0d",
                       rsp.status, rsp.is_member, rsp.entry_count);
                mismatch_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, rsp.status);
                    mismatch_count++;
                end
                if (rsp.is_member !== want.is_member)
                begin
                    $error("is_member: expected %0d, actual %0d",
                           want.is_member, rsp.is_member);
                    mismatch_count++;
                end
                if (rsp.entry_count !== want.entry_count)
                begin
                    $error("entry_count: expected %0d, actual %0d",
                           want.entry_count, rsp.entry_count);
                    mismatch_count++;
                end
            end
        end
        rsp_stall <= recv_hold || ($urandom_range(99) < recv_idle_pct);
    end

    // long receiver hold-off, counted here so the sender can keep offering items
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                recv_hold <= 1'b1;
                repeat (hold_request)
                    @(posedge clk);
                recv_hold    <= 1'b0;
                hold_request = 0;
            end
        end
    end

    // run limit
    initial
    begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge clk);
        $display("unsorted_array_set_core verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // corner cases: empty store, duplicates, compacting remove, full store
    task automatic test_directed();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_item(OP_QUERY, '0);             // query on an empty store
        send_item(OP_REMOVE, '0);            // remove from empty, not found
        send_item(OP_NOP, ALT_BITS);         // unused opcode, nothing happens
        send_item(OP_INSERT, '1);
        send_item(OP_INSERT, '0);
        send_item(OP_INSERT, '1);            // duplicate is accepted
        send_item(OP_QUERY, '1);
        send_item(OP_REMOVE, '1);            // first copy goes, later entries move down
        send_item(OP_QUERY, '1);             // second copy still held
        send_item(OP_REMOVE, '0);            // removal of the value 0, one entry left
        for (int i = 1; i < CAPACITY; i++)
            send_item(OP_INSERT, ALT_BITS ^ ValueW'(i));
        send_item(OP_INSERT, '0);            // store full, refused
        send_item(OP_REMOVE, ~ALT_BITS);     // missing value on a full store
        send_item(OP_QUERY, '1);
        wait_all_results();
    endtask

    // bursts that fill, drain or mix, under the given idling rates
    task automatic test_random_traffic(input int item_total, input int send_pct,
                                       input int recv_pct);
        int sent;
        int burst;
        int insert_pct;
        int remove_pct;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent          = 0;
        while (sent < item_total)
        begin
            burst = $urandom_range(40, 8);
            case ($urandom_range(2))
                0:       begin insert_pct = 80; remove_pct = 8;  end
                1:       begin insert_pct = 12; remove_pct = 70; end
                default: begin insert_pct = 35; remove_pct = 35; end
            endcase
            repeat (burst)
                send_random_item(insert_pct, remove_pct);
            sent += burst;
        end
        wait_all_results();
    endtask

    // receiver holds off for a long stretch, the core backs up and stalls its input
    task automatic test_receiver_holdoff();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = HOLD_CYCLES;
        repeat (HOLD_ITEMS)
            send_random_item(40, 30);
        wait_all_results();
    endtask

    initial
    begin
        value_pool[0] = '0;
        value_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            value_pool[i] = {$urandom, $urandom};

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic(PHASE_ITEMS, 9, 74);
        test_receiver_holdoff();
        test_random_traffic(PHASE_ITEMS, 74, 9);
        test_random_traffic(PHASE_ITEMS, 0, 0);

        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("unsorted_array_set_core verification clean");
        else
            $display("unsorted_array_set_core verification failed");
        $finish;
    end

endmodule

### sim.f
hdl/uaset_pkg.sv
hdl/uaset_cell.sv
hdl/unsorted_array_set_core.sv
test/testbench.sv
